FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the cycle finder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Types and constants shared by the directed cycle finder modules.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int VERTEX_W = 6;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SEARCH   = 1'b1;

  localparam logic [VERTEX_W-1:0] NODE_COUNT_RESET = 6'd32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_ROOT,
    S_LOAD,
    S_SCAN,
    S_POP,
    S_PATH,
    S_PWAIT,
    S_EMIT_RD,
    S_EMIT,
    S_NONE,
    S_CLEAR
  } dcf_state_t;

  typedef struct packed {
    logic                cycle_found;
    logic [VERTEX_W-1:0] vertex;
    logic                last;
  } dcf_result_t;

endpackage

FILE: hdl/directed_cycle_finder.sv
// ----------------------------------------------------------------------------
// directed_cycle_finder
// Loads directed edges, then searches for a cycle and reports its vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): op=0 adds edge src_vertex->dst_vertex
//   through a read-modify-write of its source row. op=1 runs the
//   search, streams the report and then clears the graph.
//   Output channel (out_valid / out_stall): one item per reported vertex,
//   head, tree path down to the back edge tail, head again; or a single
//   item with cycle_found=0 when no cycle exists. last marks the final item.
//   Search time is set by the neighbor scan loop, which checks one candidate
//   neighbor per cycle while scanning; the cycle path is then built from
//   parent links, the items are emitted and the graph is cleared.
//   in_stall is high for the whole time an item is being processed.
//   A held out_stall simply pauses the emitter; one item waits in the output
//   register while the next is fetched. Reset empties the graph, sets
//   node_count to 32 and drops any output. The user must see that node_count
//   is written via cfg_write / cfg_data while the block is idle (left unchecked).
// ----------------------------------------------------------------------------
module directed_cycle_finder #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [dcf_pkg::VERTEX_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [dcf_pkg::VERTEX_W-1:0] src_vertex,
  input  logic [dcf_pkg::VERTEX_W-1:0] dst_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         cycle_found,
  output logic [dcf_pkg::VERTEX_W-1:0] vertex,
  output logic                         last
);
  import dcf_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES + 2);

  logic [VERTEX_W-1:0] node_count;
  logic [VW-1:0]       n_eff;
  logic                res_valid, res_ready;
  dcf_result_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_write) begin
      node_count <= cfg_data;
    end
  end

  assign n_eff = (node_count > VERTEX_W'(MAX_VERTICES)) ? VW'(MAX_VERTICES)
                                                       : VW'(node_count);

  dcf_core #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .src_vertex (src_vertex),
    .dst_vertex (dst_vertex),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      cycle_found <= res.cycle_found;
      vertex      <= res.vertex;
      last        <= res.last;
    end
  end

endmodule

FILE: hdl/dcf_core.sv
// ----------------------------------------------------------------------------
// dcf_core
// Edge store and depth-first search sequencer with explicit stack, cycle path
// builder and result emitter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcf_core #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(MAX_VERTICES+2)-1:0]     n_eff,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic [dcf_pkg::VERTEX_W-1:0]          src_vertex,
  input  logic [dcf_pkg::VERTEX_W-1:0]          dst_vertex,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output dcf_pkg::dcf_result_t                  res
);
  import dcf_pkg::*;

  localparam int IW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VW  = $clog2(MAX_VERTICES + 2);
  localparam int DW  = $clog2(MAX_VERTICES + 1);
  localparam int PD  = MAX_VERTICES + 1;
  localparam int PIW = $clog2(PD);
  localparam int CW  = $clog2(PD + 1);

  typedef struct packed {
    logic [VW-1:0] vert;
    logic [VW-1:0] nxt;
  } stk_entry_t;

  dcf_state_t state, state_next;

  logic [VW-1:0]           u, v, root, cur;
  logic [DW-1:0]           depth;
  logic [MAX_VERTICES-1:0] row, gray, black, row_valid;
  logic                    back_seen;
  logic [VW-1:0]           back_tail, back_head;
  logic [IW-1:0]           edge_src, edge_dst;
  logic [CW-1:0]           cnt;
  logic [PIW-1:0]          pidx;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic                    adj_rd_ok;
  logic [IW-1:0]           adj_addr;
  stk_entry_t              stk_mem [MAX_VERTICES];
  stk_entry_t              stk_rdata;
  logic [VW-1:0]           par_mem [MAX_VERTICES];
  logic [VW-1:0]           par_rdata;
  logic [VW-1:0]           pbuf [PD];
  logic [VW-1:0]           pb_rdata;

  logic                    accept, edge_ok;
  logic [VERTEX_W-1:0]     src_m1, dst_m1;
  logic [VW-1:0]           vm1, um1, rm1, cm1, pop_m1;
  logic [IW-1:0]           v_idx, u_idx, r_idx, c_idx;
  logic [DW-1:0]           dm1, dm2;
  logic                    v_over, root_over, hit, v_white, full, push, pop_done;
  logic                    path_end, path_full;

  assign accept  = in_valid && !in_stall;
  assign src_m1  = src_vertex - VERTEX_W'(1);
  assign dst_m1  = dst_vertex - VERTEX_W'(1);
  assign edge_ok = (src_vertex != '0) && (src_vertex <= VERTEX_W'(MAX_VERTICES)) &&
                   (dst_vertex != '0) && (dst_vertex <= VERTEX_W'(MAX_VERTICES));

  assign vm1    = v - VW'(1);
  assign um1    = u - VW'(1);
  assign rm1    = root - VW'(1);
  assign cm1    = cur - VW'(1);
  assign pop_m1 = stk_rdata.vert - VW'(1);
  assign v_idx  = vm1[IW-1:0];
  assign u_idx  = um1[IW-1:0];
  assign r_idx  = rm1[IW-1:0];
  assign c_idx  = cm1[IW-1:0];
  assign dm1    = depth - DW'(1);
  assign dm2    = depth - DW'(2);

  assign v_over    = v > n_eff;
  assign root_over = root > n_eff;
  assign hit       = row[v_idx];
  assign v_white   = !gray[v_idx] && !black[v_idx];
  assign full      = depth == DW'(MAX_VERTICES);
  assign push      = !v_over && hit && v_white && !full;
  assign pop_done  = depth == DW'(1);
  assign path_full = cnt == CW'(PD);
  assign path_end  = cur == back_head;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_SEARCH) state_next = S_ROOT;
          else if (edge_ok)    state_next = S_ADD;
        end
      end
      S_ADD:   state_next = S_IDLE;
      S_ROOT: begin
        if (root_over)                         state_next = back_seen ? S_PATH : S_NONE;
        else if (!gray[r_idx] && !black[r_idx]) state_next = S_LOAD;
      end
      S_LOAD:  state_next = S_SCAN;
      S_SCAN: begin
        if (v_over)    state_next = pop_done ? S_ROOT : S_POP;
        else if (push) state_next = S_LOAD;
      end
      S_POP:   state_next = S_LOAD;
      S_PATH: begin
        if (path_full || path_end) state_next = S_EMIT_RD;
        else                       state_next = S_PWAIT;
      end
      S_PWAIT:   state_next = S_PATH;
      S_EMIT_RD: state_next = S_EMIT;
      S_EMIT: begin
        if (res_ready) state_next = (pidx == '0) ? S_CLEAR : S_EMIT_RD;
      end
      S_NONE:  if (res_ready) state_next = S_CLEAR;
      S_CLEAR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall        = state != S_IDLE;
    res_valid       = 1'b0;
    res.cycle_found = 1'b0;
    res.vertex      = '0;
    res.last        = 1'b1;
    case (state)
      S_EMIT: begin
        res_valid       = 1'b1;
        res.cycle_found = 1'b1;
        res.vertex      = VERTEX_W'(pb_rdata);
        res.last        = pidx == '0;
      end
      S_NONE:  res_valid = 1'b1;
      default: res_valid = 1'b0;
    endcase
  end

  always_comb begin
    case (state)
      S_ROOT:  adj_addr = r_idx;
      S_POP:   adj_addr = pop_m1[IW-1:0];
      S_SCAN:  adj_addr = v_idx;
      default: adj_addr = src_m1[IW-1:0];
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    adj_rdata <= adj_mem[adj_addr];
    stk_rdata <= stk_mem[dm2[IW-1:0]];
    par_rdata <= par_mem[c_idx];
    pb_rdata  <= pbuf[pidx];
    if (state == S_ADD) begin
      adj_mem[edge_src] <= (adj_rd_ok ? adj_rdata : '0) |
                           (MAX_VERTICES'(1) << edge_dst);
    end
    if (state == S_SCAN && push) begin
      stk_mem[dm1[IW-1:0]] <= '{vert: u, nxt: v + VW'(1)};
      par_mem[v_idx]       <= u;
    end
    if (state == S_ROOT && root_over) pbuf[0] <= back_head;
    if (state == S_PATH && !path_full) pbuf[cnt[PIW-1:0]] <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      gray      <= '0;
      black     <= '0;
      adj_rd_ok <= 1'b0;
      back_seen <= 1'b0;
      depth     <= '0;
    end else begin
      state     <= state_next;
      adj_rd_ok <= row_valid[adj_addr];
      case (state)
        S_IDLE: begin
          edge_src  <= src_m1[IW-1:0];
          edge_dst  <= dst_m1[IW-1:0];
          root      <= VW'(1);
          back_seen <= 1'b0;
          depth     <= '0;
        end
        S_ADD: row_valid[edge_src] <= 1'b1;
        S_ROOT: begin
          if (root_over) begin
            cnt <= CW'(1);
            cur <= back_tail;
          end else if (!gray[r_idx] && !black[r_idx]) begin
            gray[r_idx] <= 1'b1;
            u     <= root;
            v     <= VW'(1);
            depth <= DW'(1);
          end else begin
            root <= root + VW'(1);
          end
        end
        S_LOAD: row <= adj_rd_ok ? adj_rdata : '0;
        S_SCAN: begin
          if (v_over) begin
            gray[u_idx]  <= 1'b0;
            black[u_idx] <= 1'b1;
            depth        <= dm1;
            if (pop_done) root <= root + VW'(1);
          end else if (push) begin
            gray[v_idx] <= 1'b1;
            u     <= v;
            v     <= VW'(1);
            depth <= depth + DW'(1);
          end else begin
            // back edge to an open ancestor; the last one found wins
            if (hit && gray[v_idx]) begin
              back_seen <= 1'b1;
              back_tail <= u;
              back_head <= v;
            end
            v <= v + VW'(1);
          end
        end
        S_POP: begin
          u <= stk_rdata.vert;
          v <= stk_rdata.nxt;
        end
        S_PATH: begin
          if (path_full) begin
            pidx <= PIW'(cnt - CW'(1));
          end else begin
            cnt <= cnt + CW'(1);
            if (path_end) pidx <= cnt[PIW-1:0];
          end
        end
        S_PWAIT: cur <= par_rdata;
        S_EMIT:  if (res_ready && pidx != '0) pidx <= pidx - PIW'(1);
        S_CLEAR: begin
          row_valid <= '0;
          gray      <= '0;
          black     <= '0;
          depth     <= '0;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_color_disjoint, clk, rst, (gray & black) == '0, "vertex both gray and black")
  `ASSERT_ALWAYS(a_depth_bound, clk, rst, depth <= DW'(MAX_VERTICES), "stack depth overflow")
  `ASSERT_IMPLIES(a_scan_gray, clk, rst, state == S_SCAN, gray[u_idx], "scanning a closed vertex")
  `ASSERT_NEXT(a_clear, clk, rst, state == S_CLEAR, (gray == '0) && (row_valid == '0), "graph not cleared")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Directed cycle finder test: edge loads and search items are sent with random
// gaps, each report is predicted by an in-bench depth-first search and checked
// field by field against the output stream, across several node_count values.
// ----------------------------------------------------------------------------
module tb;
  import dcf_pkg::*;

  localparam int MAXV = 32;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic                cyc;
    logic [VERTEX_W-1:0] vtx;
    logic                lst;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [VERTEX_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_ADD_EDGE;
  logic [VERTEX_W-1:0] src_vertex = '0;
  logic [VERTEX_W-1:0] dst_vertex = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cycle_found;
  logic [VERTEX_W-1:0] vertex;
  logic last;

  directed_cycle_finder #(.MAX_VERTICES(MAXV)) dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .src_vertex(src_vertex), .dst_vertex(dst_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .cycle_found(cycle_found), .vertex(vertex), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [MAXV:1] graph_rows [1:MAXV];
  logic [1:0]    paint [1:MAXV];
  logic [5:0]    up_link [1:MAXV];
  logic [5:0]    vertex_limit;
  report_t       report_q [$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  task automatic clear_graph();
    for (int i = 1; i <= MAXV; i++) begin
      graph_rows[i] = '0;
      paint[i] = 2'd0;
      up_link[i] = '0;
    end
  endtask

  function automatic bit has_edge(int u, int v);
    return graph_rows[u][v];
  endfunction

  // depth-first search with explicit stack; queues the predicted report and clears the graph
  task automatic predict_report();
    int n, depth, u, v, cur, cnt;
    int st_v [MAXV];
    int st_n [MAXV];
    int path [MAXV+2];
    bit seen;
    int b_tail, b_head;
    n = (vertex_limit > MAXV) ? MAXV : vertex_limit;
    seen = 0; b_tail = 0; b_head = 0;
    for (int r = 1; r <= n; r++) begin
      if (paint[r] != 2'd0) continue;
      paint[r] = 2'd1;
      up_link[r] = '0;
      st_v[0] = r; st_n[0] = 1; depth = 1;
      while (depth > 0) begin
        u = st_v[depth-1];
        v = st_n[depth-1];
        while (v <= n && !has_edge(u, v)) v++;
        if (v > n) begin
          paint[u] = 2'd2;
          depth--;
          continue;
        end
        st_n[depth-1] = v + 1;
        if (paint[v] == 2'd0) begin
          if (depth < MAXV) begin
            up_link[v] = u[5:0];
            paint[v] = 2'd1;
            st_v[depth] = v; st_n[depth] = 1;
            depth++;
          end
        end else if (paint[v] == 2'd1) begin
          seen = 1; b_tail = u; b_head = v;
        end
      end
    end
    if (seen) begin
      cnt = 0;
      cur = b_tail;
      path[cnt++] = b_head;
      while (cnt < MAXV + 1 && cur >= 1 && cur <= MAXV) begin
        path[cnt++] = cur;
        if (cur == b_head) break;
        cur = up_link[cur];
      end
      for (int k = 0; k < cnt; k++)
        report_q.push_back('{1'b1, path[cnt-1-k][5:0], (k + 1 == cnt)});
    end else begin
      report_q.push_back('{1'b0, 6'd0, 1'b1});
    end
    clear_graph();
  endtask

  // called at a falling edge; in_valid drops at the falling edge after each accepted item
  task automatic send_item(logic o, logic [5:0] s, logic [5:0] d);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 28) @(negedge clk);
    op <= o; src_vertex <= s; dst_vertex <= d; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (o == OP_ADD_EDGE) begin
      if (s >= 1 && s <= MAXV && d >= 1 && d <= MAXV) graph_rows[s][d] = 1'b1;
    end else begin
      predict_report();
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic load_edge(int s, int d);
    send_item(OP_ADD_EDGE, s[5:0], d[5:0]);
  endtask

  task automatic search();
    send_item(OP_SEARCH, 6'($urandom), 6'($urandom));
  endtask

  task automatic drain();
    while (report_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_node_count(int n);
    drain();
    cfg_data <= n[5:0]; cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    vertex_limit = n[5:0];
  endtask

  // receiver: random stalls, check each accepted item
  always @(negedge clk) begin
    out_stall <= (!no_idle && $urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    report_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %b %0d %b", cycle_found, vertex, last);
      end else begin
        exp_r = report_q.pop_front();
        if (exp_r.cyc !== cycle_found || exp_r.vtx !== vertex || exp_r.lst !== last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %b %0d %b got %b %0d %b",
                     exp_r.cyc, exp_r.vtx, exp_r.lst, cycle_found, vertex, last);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed();
    search();                       // empty graph
    load_edge(5, 5); search();      // self loop
    load_edge(1, 2); load_edge(2, 3); load_edge(3, 1); search();
    load_edge(0, 1); load_edge(1, 0); load_edge(33, 2); load_edge(63, 63);
    load_edge(2, 1); search();      // ignored edges, then a single edge (no cycle)
    load_edge(1, 2); load_edge(2, 4); search();   // acyclic
    load_edge(32, 1); load_edge(1, 32); search(); // extreme vertices
  endtask

  task automatic test_node_count_limits();
    set_node_count(3);
    load_edge(4, 5); load_edge(5, 4); load_edge(1, 2); search(); // beyond count
    set_node_count(0);
    load_edge(1, 1); search();
    set_node_count(63);
    load_edge(31, 32); load_edge(32, 31); search();
    set_node_count(1);
    load_edge(1, 1); search();
  endtask

  // count random edges among vertices 1..n, about one in ten drawn from 0..63, then a search
  task automatic random_graph(int n, int count);
    int a, b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        a = $urandom_range(63); b = $urandom_range(63);
      end else begin
        a = $urandom_range(n, 1); b = $urandom_range(n, 1);
      end
      load_edge(a, b);
    end
    search();
  endtask

  task automatic test_random();
    int sizes [5] = '{32, 4, 8, 12, 2};
    int sent;
    sent = 0;
    foreach (sizes[i]) begin
      set_node_count(sizes[i]);
      no_idle = (i == 2);
      for (int g = 0; g < 8; g++) begin
        int k;
        k = $urandom_range(sizes[i] + 3, 1);
        random_graph(sizes[i], k);
        sent += k + 1;
      end
    end
    no_idle = 1'b0;
    set_node_count(6);
    while (sent < 410) begin
      int k;
      k = $urandom_range(6, 1);
      random_graph(6, k);
      sent += k + 1;
    end
  endtask

  initial begin
    vertex_limit = NODE_COUNT_RESET;
    clear_graph();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (40) @(negedge clk);
    test_directed();
    test_node_count_limits();
    test_random();
    drain();
    if (errors == 0 && report_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/dcf_pkg.sv
hdl/dcf_core.sv
hdl/directed_cycle_finder.sv
tb/tb.sv
